// File: rtl/cvmg_pkg.sv
// Shared types and constants for the CV to MIDI message generator.
`default_nettype none

package cvmg_pkg;

  localparam int VOICES_DEF    = 16;
  localparam int EVENT_CAP_DEF = 512;
  localparam int CNT_W         = 10;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = 2;
  localparam int FIFO_CNT_W    = 3;
  localparam int MAX_MSGS      = 3;

  localparam logic [7:0]  ST_NOTE_OFF   = 8'h80;
  localparam logic [7:0]  ST_NOTE_ON    = 8'h90;
  localparam logic [7:0]  ST_POLY_PRES  = 8'hA0;
  localparam logic [7:0]  ST_CTRL       = 8'hB0;
  localparam logic [7:0]  ST_BEND       = 8'hE0;
  localparam logic [6:0]  CC_MOD_WHEEL  = 7'd1;
  localparam logic [6:0]  NOTE_RESET    = 7'd60;
  localparam logic [7:0]  VAL_UNSET     = 8'hFF;
  localparam logic [13:0] BEND_CENTER   = 14'h2000;
  localparam logic [31:0] FRAME_NOT_RDY = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ACT_VOICE = 3'd0,
    ACT_BEND  = 3'd1,
    ACT_WHEEL = 3'd2,
    ACT_TICK  = 3'd3,
    ACT_START = 3'd4,
    ACT_RESET = 3'd5
  } action_t;

  typedef struct packed {
    logic [6:0] note;
    logic       gate;
    logic [7:0] pres;
  } voice_t;

  localparam voice_t VOICE_RESET = '{note: NOTE_RESET, gate: 1'b0, pres: VAL_UNSET};

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } vmem_ctl_t;

  typedef struct packed {
    logic [7:0]  status_byte;
    logic [6:0]  data_one;
    logic [6:0]  data_two;
    logic [31:0] timestamp;
    logic        last;
  } msg_t;

endpackage

`default_nettype wire

// File: rtl/cvmg_ifs.sv
// Valid/ready channel interfaces for control input items and MIDI messages.
`default_nettype none

interface cvmg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [3:0]  voice;
  logic [6:0]  note;
  logic        gate;
  logic [6:0]  velocity;
  logic [6:0]  pressure;
  logic [13:0] bend_value;
  logic [6:0]  wheel_value;
  logic [31:0] frame_start;

  modport source (
    output valid, action, voice, note, gate, velocity, pressure, bend_value,
           wheel_value, frame_start,
    input  ready
  );
  modport sink (
    input  valid, action, voice, note, gate, velocity, pressure, bend_value,
           wheel_value, frame_start,
    output ready
  );
endinterface

interface cvmg_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  status_byte;
  logic [6:0]  data_one;
  logic [6:0]  data_two;
  logic [31:0] timestamp;
  logic        last;

  modport source (
    output valid, status_byte, data_one, data_two, timestamp, last,
    input  ready
  );
  modport sink (
    input  valid, status_byte, data_one, data_two, timestamp, last,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/cvmg_voice_mem.sv
// Per-voice state memory with valid bits, registered read and write bypass.
`default_nettype none

module cvmg_voice_mem #(
  parameter int VOICES = cvmg_pkg::VOICES_DEF,
  parameter int VIDX_W = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cvmg_pkg::vmem_ctl_t ctl,
  input  wire logic [VIDX_W-1:0]   rd_addr,
  input  wire logic [VIDX_W-1:0]   wr_addr,
  input  wire cvmg_pkg::voice_t    wr_data,
  output      cvmg_pkg::voice_t    rd_data
);
  import cvmg_pkg::*;

  voice_t              mem_r [VOICES];
  voice_t              q_r;
  voice_t              bypd_r;
  logic                byp_r;
  logic [VIDX_W-1:0]   raddr_r;
  logic [VOICES-1:0]   vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      q_r     <= mem_r[rd_addr];
      bypd_r  <= wr_data;
      raddr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      byp_r <= 1'b0;
    end else begin
      if (ctl.clr) begin
        vld_r <= '0;
      end else if (ctl.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        byp_r <= ctl.wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_comb begin
    if (byp_r) begin
      rd_data = bypd_r;
    end else if (vld_r[raddr_r]) begin
      rd_data = q_r;
    end else begin
      rd_data = VOICE_RESET;
    end
  end

endmodule

`default_nettype wire

// File: rtl/cvmg_msg_fifo.sv
// Result queue taking up to three messages per cycle and draining one per cycle when out_ch is ready.
`default_nettype none

module cvmg_msg_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [1:0]        push_n,
  input  wire cvmg_pkg::msg_t    push_msg [cvmg_pkg::MAX_MSGS],
  output      logic              room,
  cvmg_out_if.source             out_ch
);
  import cvmg_pkg::*;

  msg_t                  buf_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r;
  logic [FIFO_PTR_W-1:0] rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;
  logic                  pop;
  msg_t                  head;

  assign room = cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - MAX_MSGS);
  assign pop  = out_ch.valid && out_ch.ready;
  assign head = buf_r[rd_ptr_r];

  assign out_ch.valid       = cnt_r != '0;
  assign out_ch.status_byte = head.status_byte;
  assign out_ch.data_one    = head.data_one;
  assign out_ch.data_two    = head.data_two;
  assign out_ch.timestamp   = head.timestamp;
  assign out_ch.last        = head.last;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_MSGS; i++) begin
      if (2'(i) < push_n) begin
        buf_r[wr_ptr_r + FIFO_PTR_W'(i)] <= push_msg[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(pop);
      cnt_r    <= cnt_r + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

// File: rtl/cv_to_midi_message_generator.sv
// Top level: turns control values into MIDI note, pressure, bend and wheel messages.
// Path: an accepted input transaction is registered, then its messages are written into the FIFO that drives out_ch.
// Throughput: one input transaction per cycle while the message FIFO has room for three
// messages; an item's messages are pushed together, and out_ch drains one per cycle when ready.
// Reset: rst_n clears channel, scalar state and the voice valid bits at once; no clearing pass.
`default_nettype none

module cv_to_midi_message_generator #(
  parameter int VOICES         = cvmg_pkg::VOICES_DEF,
  parameter int EVENT_CAPACITY = cvmg_pkg::EVENT_CAP_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  cvmg_in_if.sink         in_ch,
  cvmg_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [3:0] cfg_wdata
);
  import cvmg_pkg::*;

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(EVENT_CAPACITY);

  logic [3:0]       chan_r;
  logic [13:0]      bend_r;
  logic [7:0]       wheel_r;
  logic [CNT_W-1:0] cnt_r;
  logic [31:0]      frame_r;

  logic             s1_vld_r;
  action_t          act_r;
  logic [3:0]       voice_r;
  logic [6:0]       note_r;
  logic             gate_r;
  logic [6:0]       vel_r;
  logic [6:0]       pres_r;
  logic [13:0]      bendv_r;
  logic [6:0]       wheelv_r;
  logic [31:0]      fstart_r;

  logic [13:0]      bend_nxt;
  logic [7:0]       wheel_nxt;
  logic [CNT_W-1:0] cnt_nxt;
  logic [31:0]      frame_nxt;

  logic             accept;
  logic             room;
  logic             s1_adv;
  vmem_ctl_t        vctl;
  voice_t           vs;
  voice_t           vwr;
  msg_t             push_msg [MAX_MSGS];
  logic [1:0]       push_n;

  logic             frame_ok;
  logic             in_range;
  logic             can0;
  logic             held;
  logic             changed;
  logic             rising;
  logic             falling;
  logic             e_a;
  logic             e_b;
  logic             e_c;
  logic [CNT_W-1:0] cnt1;
  logic [CNT_W-1:0] cnt2;
  logic [6:0]       new_note;
  msg_t             m_a;
  msg_t             m_b;
  msg_t             m_c;
  logic [7:0]       chan8;

  assign s1_adv       = s1_vld_r && room;
  assign in_ch.ready  = !s1_vld_r || room;
  assign accept       = in_ch.valid && in_ch.ready;
  assign chan8        = {4'h0, chan_r};

  cvmg_voice_mem #(
    .VOICES (VOICES),
    .VIDX_W (VIDX_W)
  ) u_vmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (vctl),
    .rd_addr (in_ch.voice[VIDX_W-1:0]),
    .wr_addr (voice_r[VIDX_W-1:0]),
    .wr_data (vwr),
    .rd_data (vs)
  );

  cvmg_msg_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (push_n),
    .push_msg (push_msg),
    .room     (room),
    .out_ch   (out_ch)
  );

  always_comb begin
    frame_ok = frame_r != FRAME_NOT_RDY;
    in_range = {1'b0, voice_r} < 5'(VOICES);
    can0     = frame_ok && (cnt_r < CAP);
    held     = vs.gate;
    changed  = gate_r && held && (note_r != vs.note);
    rising   = gate_r && !held;
    falling  = !gate_r && held;
    new_note = can0 ? note_r : vs.note;

    vwr.note = new_note;
    vwr.gate = can0 ? gate_r : vs.gate;
    vwr.pres = {1'b0, pres_r};

    m_a = '{status_byte: ST_NOTE_OFF | chan8, data_one: vs.note, data_two: vel_r,
            timestamp: frame_r, last: 1'b0};
    m_b = '{status_byte: ST_NOTE_ON | chan8, data_one: note_r, data_two: vel_r,
            timestamp: frame_r, last: 1'b0};
    m_c = '{status_byte: ST_POLY_PRES | chan8, data_one: new_note, data_two: pres_r,
            timestamp: frame_r, last: 1'b0};

    e_a  = 1'b0;
    e_b  = 1'b0;
    e_c  = 1'b0;
    cnt1 = cnt_r;
    cnt2 = cnt_r;

    bend_nxt  = bend_r;
    wheel_nxt = wheel_r;
    cnt_nxt   = cnt_r;
    frame_nxt = frame_r;
    vctl.wr_en = 1'b0;
    vctl.clr   = 1'b0;

    case (act_r)
      ACT_VOICE: begin
        if (in_range) begin
          vctl.wr_en = s1_adv;
          e_a  = can0 && (changed || falling);
          cnt1 = cnt_r + CNT_W'(e_a);
          e_b  = can0 && (changed || rising) && (cnt1 < CAP);
          cnt2 = cnt1 + CNT_W'(e_b);
          e_c  = (vs.pres != {1'b0, pres_r}) && frame_ok && (cnt2 < CAP);
          cnt_nxt = cnt2 + CNT_W'(e_c);
        end
      end
      ACT_BEND: begin
        m_a = '{status_byte: ST_BEND | chan8, data_one: bendv_r[6:0],
                data_two: bendv_r[13:7], timestamp: frame_r, last: 1'b0};
        if (bend_r != bendv_r) begin
          bend_nxt = bendv_r;
          e_a      = can0;
          cnt_nxt  = cnt_r + CNT_W'(can0);
        end
      end
      ACT_WHEEL: begin
        m_a = '{status_byte: ST_CTRL | chan8, data_one: CC_MOD_WHEEL,
                data_two: wheelv_r, timestamp: frame_r, last: 1'b0};
        if (wheel_r != {1'b0, wheelv_r}) begin
          wheel_nxt = {1'b0, wheelv_r};
          e_a       = can0;
          cnt_nxt   = cnt_r + CNT_W'(can0);
        end
      end
      ACT_TICK: begin
        if (frame_ok) begin
          frame_nxt = frame_r + 32'd1;
        end
      end
      ACT_START: begin
        frame_nxt = fstart_r;
        cnt_nxt   = '0;
      end
      ACT_RESET: begin
        vctl.clr  = s1_adv;
        bend_nxt  = BEND_CENTER;
        wheel_nxt = VAL_UNSET;
        cnt_nxt   = '0;
        frame_nxt = FRAME_NOT_RDY;
      end
      default: begin
      end
    endcase

    vctl.rd_en = accept;

    // pack enabled messages to the front, mark the final one
    if (e_a) begin
      push_msg[0] = m_a;
      push_msg[1] = e_b ? m_b : m_c;
    end else begin
      push_msg[0] = e_b ? m_b : m_c;
      push_msg[1] = m_c;
    end
    push_msg[2] = m_c;
    push_n = s1_adv ? (2'(e_a) + 2'(e_b) + 2'(e_c)) : 2'd0;
    case (push_n)
      2'd1:    push_msg[0].last = 1'b1;
      2'd2:    push_msg[1].last = 1'b1;
      2'd3:    push_msg[2].last = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r    <= action_t'(in_ch.action);
      voice_r  <= in_ch.voice;
      note_r   <= in_ch.note;
      gate_r   <= in_ch.gate;
      vel_r    <= in_ch.velocity;
      pres_r   <= in_ch.pressure;
      bendv_r  <= in_ch.bend_value;
      wheelv_r <= in_ch.wheel_value;
      fstart_r <= in_ch.frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      chan_r   <= '0;
      bend_r   <= BEND_CENTER;
      wheel_r  <= VAL_UNSET;
      cnt_r    <= '0;
      frame_r  <= FRAME_NOT_RDY;
    end else begin
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        chan_r <= cfg_wdata;
      end
      if (s1_adv) begin
        bend_r  <= bend_nxt;
        wheel_r <= wheel_nxt;
        cnt_r   <= cnt_nxt;
        frame_r <= frame_nxt;
      end
    end
  end

endmodule

`default_nettype wire
